// ===== rtl/b64d_pkg.sv =====
// shared types, codes and character decode for the base64url decoder
`default_nettype none

package b64d_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_LEFTOVER = 3'd2,
      ST_TRAILING = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   item_kind;
      logic [7:0] data_byte;
      status_type status;
      logic       end_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] ch);
      sextet_type res;
      logic [7:0] off_upper;
      logic [7:0] off_lower;
      logic [7:0] off_digit;
      off_upper = ch - 8'd65;
      off_lower = ch - 8'd97;
      off_digit = ch - 8'd48;
      res.ok    = 1'b1;
      res.value = 6'd0;
      if (ch >= 8'd65 && ch <= 8'd90) begin
         res.value = off_upper[5:0];
      end else if (ch >= 8'd97 && ch <= 8'd122) begin
         res.value = 6'd26 + off_lower[5:0];
      end else if (ch >= 8'd48 && ch <= 8'd57) begin
         res.value = 6'd52 + off_digit[5:0];
      end else if (ch == 8'd45) begin
         res.value = 6'd62;
      end else if (ch == 8'd95) begin
         res.value = 6'd63;
      end else begin
         res.ok = 1'b0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/b64d_core.sv =====
// decode state, mode register and per-item result generation
`default_nettype none

module b64d_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic               csr_write_data,
   input  wire logic               accept,
   input  wire logic [7:0]         char_code,
   input  wire logic               is_last,
   output b64d_pkg::push_type      push
);

   logic                   strict_ff;
   logic                   strict_in;
   logic [11:0]            acc_ff;
   logic [11:0]            acc_in;
   logic [2:0]             cnt_ff;
   logic [2:0]             cnt_in;
   logic                   any_ff;
   logic                   any_in;
   b64d_pkg::status_type   err_ff;
   b64d_pkg::status_type   err_in;

   b64d_pkg::sextet_type   sx;
   logic                   active;
   logic                   take;
   logic [3:0]             cnt_sum;
   logic [3:0]             cnt_adj;
   logic                   emit;
   logic [11:0]            acc_upd;
   logic [2:0]             cnt_upd;
   logic                   any_upd;
   b64d_pkg::status_type   err_upd;
   logic [11:0]            shifted;
   logic [11:0]            mask;
   logic                   trailing_nz;
   b64d_pkg::status_type   end_status;
   b64d_pkg::result_type   byte_res;
   b64d_pkg::result_type   end_res;

   always_comb begin
      sx      = b64d_pkg::sextet_of(char_code);
      active  = (err_ff == b64d_pkg::ST_OK);
      take    = active & sx.ok;
      cnt_sum = {1'b0, cnt_ff} + 4'd6;
      emit    = take & (cnt_sum >= 4'd8);
      cnt_adj = emit ? (cnt_sum - 4'd8) : cnt_sum;
      acc_upd = take ? {acc_ff[5:0], sx.value} : acc_ff;
      cnt_upd = take ? cnt_adj[2:0] : cnt_ff;
      any_upd = any_ff | emit;
      err_upd = (active & ~sx.ok & strict_ff) ? b64d_pkg::ST_INVALID : err_ff;

      shifted     = acc_upd >> cnt_upd;
      mask        = (12'd1 << cnt_upd) - 12'd1;
      trailing_nz = |(acc_upd & mask);

      end_status = b64d_pkg::ST_OK;
      if (strict_ff) begin
         if (err_upd != b64d_pkg::ST_OK) begin
            end_status = err_upd;
         end else if (cnt_upd != 3'd0 && cnt_upd != 3'd2 && cnt_upd != 3'd4) begin
            end_status = b64d_pkg::ST_LEFTOVER;
         end else if (!any_upd) begin
            end_status = b64d_pkg::ST_EMPTY;
         end else if (trailing_nz) begin
            end_status = b64d_pkg::ST_TRAILING;
         end
      end

      byte_res.item_kind  = b64d_pkg::KIND_DATA;
      byte_res.data_byte  = shifted[7:0];
      byte_res.status     = b64d_pkg::ST_OK;
      byte_res.end_of_run = ~is_last;

      end_res.item_kind  = b64d_pkg::KIND_STATUS;
      end_res.data_byte  = 8'd0;
      end_res.status     = end_status;
      end_res.end_of_run = 1'b1;

      push.count  = accept ? ({1'b0, emit} + {1'b0, is_last}) : 2'd0;
      push.first  = emit ? byte_res : end_res;
      push.second = end_res;

      strict_in = csr_write_enable ? csr_write_data : strict_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      any_in    = any_ff;
      err_in    = err_ff;
      if (accept) begin
         if (is_last) begin
            acc_in = 12'd0;
            cnt_in = 3'd0;
            any_in = 1'b0;
            err_in = b64d_pkg::ST_OK;
         end else begin
            acc_in = acc_upd;
            cnt_in = cnt_upd;
            any_in = any_upd;
            err_in = err_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
         acc_ff    <= 12'd0;
         cnt_ff    <= 3'd0;
         any_ff    <= 1'b0;
         err_ff    <= b64d_pkg::ST_OK;
      end else begin
         strict_ff <= strict_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         any_ff    <= any_in;
         err_ff    <= err_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && is_last |=> acc_ff == 12'd0 && cnt_ff == 3'd0 && !any_ff &&
                            err_ff == b64d_pkg::ST_OK)
      else $error("segment end did not clear decode state");

   a_even_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] == 1'b0)
      else $error("pending bit count is odd");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.first.item_kind == b64d_pkg::KIND_DATA &&
                             push.second.item_kind == b64d_pkg::KIND_STATUS &&
                             !push.first.end_of_run)
      else $error("byte and status pushed out of order");

endmodule

`default_nettype wire

// ===== rtl/b64d_queue.sv =====
// small result queue taking up to two items per cycle
`default_nettype none

module b64d_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire b64d_pkg::push_type   push,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output b64d_pkg::result_type      head,
   output logic                      room
);

   localparam logic [b64d_pkg::QUEUE_CNT_W-1:0] DEPTH_C =
      b64d_pkg::QUEUE_CNT_W'(b64d_pkg::QUEUE_DEPTH);
   localparam logic [b64d_pkg::QUEUE_CNT_W-1:0] ROOM_LIMIT =
      b64d_pkg::QUEUE_CNT_W'(b64d_pkg::QUEUE_DEPTH - 2);

   b64d_pkg::result_type                entry_ff [b64d_pkg::QUEUE_DEPTH];
   logic [b64d_pkg::QUEUE_PTR_W-1:0]    wr_ff;
   logic [b64d_pkg::QUEUE_PTR_W-1:0]    wr_in;
   logic [b64d_pkg::QUEUE_PTR_W-1:0]    wr_next;
   logic [b64d_pkg::QUEUE_PTR_W-1:0]    rd_ff;
   logic [b64d_pkg::QUEUE_PTR_W-1:0]    rd_in;
   logic [b64d_pkg::QUEUE_CNT_W-1:0]    cnt_ff;
   logic [b64d_pkg::QUEUE_CNT_W-1:0]    cnt_in;
   logic                                pop;

   always_comb begin
      rsp_valid = (cnt_ff != '0);
      head      = entry_ff[rd_ff];
      room      = (cnt_ff <= ROOM_LIMIT);
      pop       = rsp_valid & ~rsp_stall;
      wr_next   = wr_ff + 1'b1;
      wr_in     = wr_ff + b64d_pkg::QUEUE_PTR_W'(push.count);
      rd_in     = pop ? (rd_ff + 1'b1) : rd_ff;
      cnt_in    = cnt_ff + b64d_pkg::QUEUE_CNT_W'(push.count)
                  - b64d_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_C)
      else $error("result queue overflow");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> cnt_ff <= ROOM_LIMIT)
      else $error("push into queue without room");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("queue count did not drop after a pop");

endmodule

`default_nettype wire

// ===== rtl/base64url_strict_decoder.sv =====
// top level of the unpadded base64url decoder
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_char_code, req_is_last
//   rsp      out        rsp_valid / rsp_stall   rsp_item_kind, rsp_data_byte,
//                                               rsp_status, rsp_end_of_run
//   csr      in         csr_write_enable        csr_write_data (strict mode)
//
// one character per cycle while req_stall is low; results are queued
// a character may make two items, and rsp moves one per cycle unless stalled
// req_stall is high while the four-entry result queue holds more than two items
// reset clears decode state and the queue and sets strict mode
`default_nettype none

module base64url_strict_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_is_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_item_kind,
   output logic [7:0]      rsp_data_byte,
   output logic [2:0]      rsp_status,
   output logic            rsp_end_of_run
);

   b64d_pkg::push_type     push;
   b64d_pkg::result_type   head;
   logic                   room;
   logic                   accept;

   assign req_stall = ~room;
   assign accept    = req_valid & room;

   b64d_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .char_code        (req_char_code),
      .is_last          (req_is_last),
      .push             (push)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .room      (room)
   );

   assign rsp_item_kind  = head.item_kind;
   assign rsp_data_byte  = head.data_byte;
   assign rsp_status     = head.status;
   assign rsp_end_of_run = head.end_of_run;

endmodule

`default_nettype wire
